>>> rtl/hcsl_pkg.sv
// Package for the chunk-size line parser: constants, types and character classes.
`default_nettype none
package hcsl_pkg;

	localparam int SIZE_BITS = 64;
	localparam int OUT_SIZE_W = 64;
	localparam int IN_DATA_W = 8;
	localparam int OUT_DATA_W = 72;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef logic [7:0] byte_t;
	typedef logic [SIZE_BITS-1:0] size_t;

	typedef enum logic [3:0] {
		PH_SIZE0 = 4'd0,
		PH_SIZE = 4'd1,
		PH_PRE_SEMI = 4'd2,
		PH_POST_SEMI = 4'd3,
		PH_NAME = 4'd4,
		PH_PRE_EQ = 4'd5,
		PH_POST_EQ = 4'd6,
		PH_VAL = 4'd7,
		PH_QSTR = 4'd8,
		PH_QESC = 4'd9,
		PH_AFTER_Q = 4'd10
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NO_HEX = 3'd1,
		ST_BAD_EXT = 3'd2,
		ST_QUOTED_CRLF = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	function automatic logic is_ws(input byte_t c);
		return (c == CH_SP) || (c == CH_TAB);
	endfunction

	function automatic logic is_digit(input byte_t c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input byte_t c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_hex(input byte_t c);
		return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
			((c >= 8'h41) && (c <= 8'h46));
	endfunction

	function automatic logic [3:0] hex_val(input byte_t c);
		logic [7:0] v;
		if (is_digit(c)) begin
			v = c - 8'h30;
		end else if ((c >= 8'h61) && (c <= 8'h66)) begin
			v = c - 8'h57;
		end else begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

	function automatic logic is_tchar(input byte_t c);
		return (c == 8'h21) || (c == 8'h23) || (c == 8'h24) || (c == 8'h25) ||
			(c == 8'h26) || (c == 8'h27) || (c == 8'h2A) || (c == 8'h2B) ||
			(c == 8'h2D) || (c == 8'h2E) || (c == 8'h5E) || (c == 8'h5F) ||
			(c == 8'h60) || (c == 8'h7C) || (c == 8'h7E) ||
			is_digit(c) || is_alpha(c);
	endfunction

	function automatic logic is_escapable(input byte_t c);
		return is_ws(c) || ((c >= 8'h21) && (c <= 8'h7E)) || (c >= 8'h80);
	endfunction

endpackage
`default_nettype wire

>>> rtl/http_chunk_size_line_parser_top.sv
// Top level of the HTTP/1.1 chunk-size line parser.
`default_nettype none
// The parser takes one byte of a chunk-size line per item on the slave stream and gives
// one result item per line: when the line ends in CR LF, or at the first byte that breaks
// the syntax. It reads the hex size, which saturates at 2^64 - 1 and is then reported with
// the overflow status, and checks the chunk extensions (optional blanks, ';', a token and
// optionally '=' with a token or a quoted string that may hold backslash pairs). Names and
// values of extensions are checked but not kept. An error result carries a size of zero,
// and after an error every byte up to and including the next LF is dropped silently; an
// error raised on an LF byte drops nothing. The final_chunk flag is set only on a clean
// line whose size is zero. A syntax error outranks an overflow. Each byte passes through
// one input register and its result lands in one output register, so the parser takes a
// byte every clock cycle while no result is held back. A result held back by the master
// side stalls the byte behind it only when that byte would produce a result of its own.
module http_chunk_size_line_parser_top (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire  [hcsl_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [7:0] byte_in
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	output logic [hcsl_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // [63:0] chunk_size,
	                                                        // [64] final_chunk,
	                                                        // [67:65] status, [71:68] zero
);
	import hcsl_pkg::*;

	// Input register stage.
	logic       valid_s1;
	byte_t      byte_s1;

	// Line state.
	phase_t     phase_q;
	size_t      acc_q;
	logic       ovf_q;
	logic       pcr_q;
	logic       drop_q;

	// Output register.
	logic                  out_valid_q;
	logic [OUT_SIZE_W-1:0] out_size_q;
	logic                  out_final_q;
	status_t               out_status_q;

	// Next-state values.
	phase_t     ph;
	phase_t     ph_n;
	size_t      acc_n;
	logic       ovf_n;
	logic       pcr_n;
	logic       drop_n;
	logic       fire;
	logic       failed;
	logic       handled;
	status_t    st;
	logic       advance;
	logic       out_free;

	// The byte in stage one is consumed unless it produces a result that cannot yet be
	// placed in the output register.
	assign out_free = !out_valid_q || m_axis_tready;
	assign advance = valid_s1 && (!fire || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	// One step of the line grammar for the byte held in stage one.
	always_comb begin
		ph_n = phase_q;
		acc_n = acc_q;
		ovf_n = ovf_q;
		pcr_n = pcr_q;
		drop_n = drop_q;
		fire = 1'b0;
		failed = 1'b0;
		handled = 1'b0;
		st = ST_OK;
		ph = phase_q;

		if (drop_q) begin
			if (byte_s1 == CH_LF) begin
				drop_n = 1'b0;
			end
		end else begin
			// A CR seen on the previous byte is resolved first.
			if (pcr_q) begin
				pcr_n = 1'b0;
				if (phase_q == PH_QSTR) begin
					if (byte_s1 == CH_LF) begin
						fire = 1'b1;
						failed = 1'b1;
						st = ST_QUOTED_CRLF;
						handled = 1'b1;
					end
				end else begin
					fire = 1'b1;
					handled = 1'b1;
					if (byte_s1 == CH_LF) begin
						st = ovf_q ? ST_OVERFLOW : ST_OK;
					end else begin
						failed = 1'b1;
						st = ST_BAD_EXT;
					end
				end
			end

			// The byte after a backslash is swallowed when it may be escaped, and is
			// otherwise read as ordinary quoted content.
			if (!handled && (phase_q == PH_QESC)) begin
				ph = PH_QSTR;
				ph_n = PH_QSTR;
				if (is_escapable(byte_s1)) begin
					handled = 1'b1;
				end
			end

			if (!handled) begin
				unique case (ph)
					PH_SIZE0, PH_SIZE: begin
						if (is_hex(byte_s1)) begin
							ph_n = PH_SIZE;
							// Multiplying by 16 overflows exactly when the top digit is in use.
							if (ovf_q || (acc_q[SIZE_BITS-1 -: 4] != 4'd0)) begin
								acc_n = '1;
								ovf_n = 1'b1;
							end else begin
								acc_n = {acc_q[SIZE_BITS-5:0], hex_val(byte_s1)};
							end
						end else if (ph == PH_SIZE0) begin
							fire = 1'b1;
							failed = 1'b1;
							st = ST_NO_HEX;
						end else if (byte_s1 == CH_CR) begin
							pcr_n = 1'b1;
						end else if (is_ws(byte_s1)) begin
							ph_n = PH_PRE_SEMI;
						end else if (byte_s1 == CH_SEMI) begin
							ph_n = PH_POST_SEMI;
						end else begin
							fire = 1'b1;
							failed = 1'b1;
							st = ST_BAD_EXT;
						end
					end
					PH_PRE_SEMI: begin
						if (byte_s1 == CH_SEMI) begin
							ph_n = PH_POST_SEMI;
						end else if (!is_ws(byte_s1)) begin
							fire = 1'b1;
							failed = 1'b1;
							st = ST_BAD_EXT;
						end
					end
					PH_POST_SEMI: begin
						if (is_tchar(byte_s1)) begin
							ph_n = PH_NAME;
						end else if (!is_ws(byte_s1)) begin
							fire = 1'b1;
							failed = 1'b1;
							st = ST_BAD_EXT;
						end
					end
					PH_NAME: begin
						if (is_tchar(byte_s1)) begin
							ph_n = PH_NAME;
						end else if (byte_s1 == CH_SEMI) begin
							ph_n = PH_POST_SEMI;
						end else if (byte_s1 == CH_CR) begin
							pcr_n = 1'b1;
						end else if (is_ws(byte_s1)) begin
							ph_n = PH_PRE_EQ;
						end else if (byte_s1 == CH_EQ) begin
							ph_n = PH_POST_EQ;
						end else begin
							fire = 1'b1;
							failed = 1'b1;
							st = ST_BAD_EXT;
						end
					end
					PH_PRE_EQ: begin
						if (byte_s1 == CH_EQ) begin
							ph_n = PH_POST_EQ;
						end else if (!is_ws(byte_s1)) begin
							fire = 1'b1;
							failed = 1'b1;
							st = ST_BAD_EXT;
						end
					end
					PH_POST_EQ: begin
						if (byte_s1 == CH_DQUOTE) begin
							ph_n = PH_QSTR;
						end else if (is_tchar(byte_s1)) begin
							ph_n = PH_VAL;
						end else if (!is_ws(byte_s1)) begin
							fire = 1'b1;
							failed = 1'b1;
							st = ST_BAD_EXT;
						end
					end
					PH_VAL, PH_AFTER_Q: begin
						if ((ph == PH_VAL) && is_tchar(byte_s1)) begin
							ph_n = PH_VAL;
						end else if (byte_s1 == CH_CR) begin
							pcr_n = 1'b1;
						end else if (is_ws(byte_s1)) begin
							ph_n = PH_PRE_SEMI;
						end else if (byte_s1 == CH_SEMI) begin
							ph_n = PH_POST_SEMI;
						end else begin
							fire = 1'b1;
							failed = 1'b1;
							st = ST_BAD_EXT;
						end
					end
					PH_QSTR: begin
						if (byte_s1 == CH_DQUOTE) begin
							ph_n = PH_AFTER_Q;
						end else if (byte_s1 == CH_BSLASH) begin
							ph_n = PH_QESC;
						end else if (byte_s1 == CH_CR) begin
							pcr_n = 1'b1;
						end
					end
					default: begin
						// Unused phase codes restart the line.
						ph_n = PH_SIZE0;
						acc_n = '0;
						ovf_n = 1'b0;
						pcr_n = 1'b0;
					end
				endcase
			end

			// A result always starts a fresh line.
			if (fire) begin
				ph_n = PH_SIZE0;
				acc_n = '0;
				ovf_n = 1'b0;
				pcr_n = 1'b0;
				if (failed && (byte_s1 != CH_LF)) begin
					drop_n = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q <= PH_SIZE0;
			acc_q <= '0;
			ovf_q <= 1'b0;
			pcr_q <= 1'b0;
			drop_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				phase_q <= ph_n;
				acc_q <= acc_n;
				ovf_q <= ovf_n;
				pcr_q <= pcr_n;
				drop_q <= drop_n;
			end
			if (advance && fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
		if (advance && fire) begin
			out_size_q <= ((st == ST_OK) || (st == ST_OVERFLOW)) ?
				OUT_SIZE_W'(acc_q) : '0;
			out_final_q <= (st == ST_OK) && (acc_q == '0);
			out_status_q <= st;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {4'd0, out_status_q, out_final_q, out_size_q};

	// An error result never carries a size.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q != ST_OK) && (out_status_q != ST_OVERFLOW))
		|-> (out_size_q == '0))
		else $error("error result carries a non-zero size");

	// The final-chunk flag belongs only to a clean line of size zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_final_q) |-> ((out_status_q == ST_OK) && (out_size_q == '0)))
		else $error("final chunk flag on a bad or non-empty line");

	// Skipping to LF and waiting on a CR exclude each other.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(drop_q && pcr_q))
		else $error("pending CR while dropping bytes");

	// A result is only produced into a free output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && fire && out_valid_q && !m_axis_tready) |=> $stable(out_size_q))
		else $error("pending result overwritten");

endmodule
`default_nettype wire
